// ===== rtl/keyword_lexer_stream_defines.svh =====
// Assertion macros for the lexer checks.
// Both macros expect clk and arst_n in scope.
`ifndef KEYWORD_LEXER_STREAM_DEFINES_SVH
`define KEYWORD_LEXER_STREAM_DEFINES_SVH

// Same-cycle implication.
`define KLS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyword lexer check failed");

// Next-cycle implication.
`define KLS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyword lexer check failed");

`endif

// ===== rtl/kls_pkg.sv =====
package kls_pkg;

	typedef enum logic [3:0] {
		KIND_KEYWORD = 4'd0,
		KIND_IDENT   = 4'd1,
		KIND_NUMBER  = 4'd2,
		KIND_SEMI    = 4'd3,
		KIND_LPAREN  = 4'd4,
		KIND_RPAREN  = 4'd5,
		KIND_LBRACK  = 4'd6,
		KIND_RBRACK  = 4'd7,
		KIND_LBRACE  = 4'd8,
		KIND_RBRACE  = 4'd9,
		KIND_DOT     = 4'd10,
		KIND_COMMA   = 4'd11
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_HASH_START   = 2'd1,
		ERR_LETTER_DIGIT = 2'd2,
		ERR_ILLEGAL      = 2'd3
	} err_t;

	localparam int NUM_KEYWORDS = 4;
	localparam int TEXT_W       = 64;
	localparam int TEXT_BYTES   = 8;
	localparam int LEN_W        = 8;

	localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;
	localparam logic [7:0] CH_HASH    = 8'd35;
	localparam logic [7:0] CH_UNDER   = 8'd95;
	localparam logic [7:0] CH_DOLLAR  = 8'd36;
	localparam logic [7:0] CH_DIGIT_0 = 8'd48;
	localparam logic [7:0] CH_DIGIT_9 = 8'd57;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_SEMI    = 8'd59;
	localparam logic [7:0] CH_LPAREN  = 8'd40;
	localparam logic [7:0] CH_RPAREN  = 8'd41;
	localparam logic [7:0] CH_LBRACK  = 8'd91;
	localparam logic [7:0] CH_RBRACK  = 8'd93;
	localparam logic [7:0] CH_LBRACE  = 8'd123;
	localparam logic [7:0] CH_RBRACE  = 8'd125;
	localparam logic [7:0] CH_DOT     = 8'd46;
	localparam logic [7:0] CH_COMMA   = 8'd44;

	localparam logic [TEXT_W-1:0] KW0_RESET = 64'd7630441;
	localparam logic [TEXT_W-1:0] KW1_RESET = 64'd1852399981;
	localparam logic [TEXT_W-1:0] KW2_RESET = 64'd1684631414;
	localparam logic [TEXT_W-1:0] KW3_RESET = 64'd499850898534;

	typedef enum logic [1:0] {
		REG_KEYWORD_0 = 2'd0,
		REG_KEYWORD_1 = 2'd1,
		REG_KEYWORD_2 = 2'd2,
		REG_KEYWORD_3 = 2'd3
	} reg_idx_t;

	typedef logic [NUM_KEYWORDS-1:0][TEXT_W-1:0] kw_arr_t;

	typedef struct packed {
		kind_t             kind;
		logic [1:0]        kidx;
		logic [TEXT_W-1:0] text;
		logic [LEN_W-1:0]  len;
		logic              trunc;
		err_t              err;
		logic              last;
	} tok_t;

	typedef struct packed {
		logic v0;
		logic v1;
		tok_t t0;
		tok_t t1;
	} pair_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} punct_t;

	function automatic punct_t punct_decode(logic [7:0] c);
		punct_t p;
		p.hit = 1'b1;
		p.kind = KIND_SEMI;
		unique case (c)
			CH_SEMI:   p.kind = KIND_SEMI;
			CH_LPAREN: p.kind = KIND_LPAREN;
			CH_RPAREN: p.kind = KIND_RPAREN;
			CH_LBRACK: p.kind = KIND_LBRACK;
			CH_RBRACK: p.kind = KIND_RBRACK;
			CH_LBRACE: p.kind = KIND_LBRACE;
			CH_RBRACE: p.kind = KIND_RBRACE;
			CH_DOT:    p.kind = KIND_DOT;
			CH_COMMA:  p.kind = KIND_COMMA;
			default:   p.hit = 1'b0;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/kls_core.sv =====
module kls_core #(
	parameter int MAX_TOKEN_CHARS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     char_in,
	input  kls_pkg::kw_arr_t kw,
	input  logic           room,
	output logic           push,
	output kls_pkg::pair_t pair
);
	import kls_pkg::*;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              in_word_q, in_number_q, halted_q;
	logic [TEXT_W-1:0] text_q;
	logic [LEN_W-1:0]  len_q;

	logic              proc;
	logic              is_alpha, wordch, digit, trunc;
	punct_t            pd;
	logic [TEXT_W-1:0] app_text;
	logic [LEN_W-1:0]  app_len;
	tok_t              pend_tok, second_tok;
	logic              do_append, do_clear, emit_pend, has_second;
	logic              nxt_word, nxt_number;
	err_t              err;

	assign proc     = valid_s1 && room;
	assign in_ready = !valid_s1 || proc;
	assign push     = proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	assign is_alpha = (char_s1 >= CH_UPPER_A && char_s1 <= CH_UPPER_Z) ||
	                  (char_s1 >= CH_LOWER_A && char_s1 <= CH_LOWER_Z);
	assign wordch   = is_alpha || char_s1 == CH_HASH || char_s1 == CH_UNDER ||
	                  char_s1 == CH_DOLLAR;
	assign digit    = char_s1 >= CH_DIGIT_0 && char_s1 <= CH_DIGIT_9;
	assign pd       = punct_decode(char_s1);
	assign trunc    = len_q > LEN_W'(MAX_TOKEN_CHARS);
	assign app_len  = (len_q == LEN_MAX) ? len_q : len_q + 8'd1;

	always_comb begin
		for (int i = 0; i < TEXT_BYTES; i++) begin
			if (i < MAX_TOKEN_CHARS && len_q == LEN_W'(i)) begin
				app_text[i*8 +: 8] = char_s1;
			end else begin
				app_text[i*8 +: 8] = text_q[i*8 +: 8];
			end
		end
	end

	// pending word or number as a token
	always_comb begin
		pend_tok       = '0;
		pend_tok.kind  = in_word_q ? KIND_IDENT : KIND_NUMBER;
		pend_tok.text  = text_q;
		pend_tok.len   = len_q;
		pend_tok.trunc = trunc;
		pend_tok.err   = ERR_NONE;
		if (in_word_q && !trunc) begin
			priority if (text_q == kw[0]) begin
				pend_tok.kind = KIND_KEYWORD;
				pend_tok.kidx = 2'd0;
			end else if (text_q == kw[1]) begin
				pend_tok.kind = KIND_KEYWORD;
				pend_tok.kidx = 2'd1;
			end else if (text_q == kw[2]) begin
				pend_tok.kind = KIND_KEYWORD;
				pend_tok.kidx = 2'd2;
			end else if (text_q == kw[3]) begin
				pend_tok.kind = KIND_KEYWORD;
				pend_tok.kidx = 2'd3;
			end else begin
				pend_tok.kind = KIND_IDENT;
			end
		end
	end

	always_comb begin
		err        = ERR_NONE;
		do_append  = 1'b0;
		do_clear   = 1'b0;
		emit_pend  = 1'b0;
		nxt_word   = in_word_q;
		nxt_number = in_number_q;
		if (!halted_q) begin
			if (wordch) begin
				if (!in_word_q && char_s1 == CH_HASH) begin
					err = ERR_HASH_START;
				end else if (in_number_q && !in_word_q) begin
					err = ERR_LETTER_DIGIT;
				end else begin
					do_append = 1'b1;
					nxt_word  = 1'b1;
				end
			end else if (digit) begin
				do_append  = 1'b1;
				nxt_number = !in_word_q;
			end else begin
				do_clear  = 1'b1;
				emit_pend = in_word_q || in_number_q;
				if (!pd.hit && char_s1 != CH_SPACE) begin
					err = ERR_ILLEGAL;
				end
			end
		end
	end

	always_comb begin
		second_tok = '0;
		if (err != ERR_NONE) begin
			second_tok.kind = KIND_KEYWORD;
			second_tok.err  = err;
		end else begin
			second_tok.kind = pd.kind;
			second_tok.text = TEXT_W'(char_s1);
			second_tok.len  = 8'd1;
			second_tok.err  = ERR_NONE;
		end
		has_second = (err != ERR_NONE) || (!halted_q && !wordch && !digit && pd.hit);

		pair = '0;
		if (emit_pend) begin
			pair.v0 = 1'b1;
			pair.t0 = pend_tok;
			pair.v1 = has_second;
			pair.t1 = second_tok;
		end else begin
			pair.v0 = has_second;
			pair.t0 = second_tok;
		end
		pair.t0.last = !pair.v1;
		pair.t1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q   <= 1'b0;
			in_number_q <= 1'b0;
			halted_q    <= 1'b0;
			text_q      <= '0;
			len_q       <= '0;
		end else if (proc) begin
			if (do_clear || err != ERR_NONE) begin
				in_word_q   <= 1'b0;
				in_number_q <= 1'b0;
				text_q      <= '0;
				len_q       <= '0;
			end else if (do_append) begin
				in_word_q   <= nxt_word;
				in_number_q <= nxt_number;
				text_q      <= app_text;
				len_q       <= app_len;
			end
			if (err != ERR_NONE) begin
				halted_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/kls_outbuf.sv =====
module kls_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kls_pkg::pair_t pair,
	output logic           room,
	output logic           token_valid,
	input  logic           token_ready,
	output kls_pkg::tok_t  head
);
	import kls_pkg::*;

	logic valid_a_q, valid_b_q;
	tok_t tok_a_q, tok_b_q;
	logic pop;

	assign pop         = valid_a_q && token_ready;
	assign room        = !valid_a_q || (pop && !valid_b_q);
	assign token_valid = valid_a_q;
	assign head        = tok_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_a_q <= 1'b0;
			valid_b_q <= 1'b0;
		end else if (push && pair.v0) begin
			valid_a_q <= 1'b1;
			valid_b_q <= pair.v1;
		end else if (pop) begin
			valid_a_q <= valid_b_q;
			valid_b_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pair.v0) begin
			tok_a_q <= pair.t0;
			tok_b_q <= pair.t1;
		end else if (pop && valid_b_q) begin
			tok_a_q <= tok_b_q;
		end
	end

endmodule

// ===== rtl/keyword_lexer_stream.sv =====
// Keyword lexer, one character per word on the input channel.
// Input: in_valid/in_ready carry char_in. Output: token_valid/token_ready carry one
// token per word (kind, keyword index, text, length, truncation flag, error code,
// last_of_run on the final token caused by a character).
// Config: cfg_we writes cfg_data into keyword register cfg_index (0..3) at once;
// write only while the block is idle.
// An accepted character is registered, then its tokens go to the result register.
// Throughput: one character per cycle while the result register has room;
// punctuation or an illegal character that closes a word or number yields two
// tokens, holding input while the second drains from the two-slot result register.
// The character register takes a new character while results wait downstream;
// when the receiver stalls, tokens hold steady and input stops after one more.
// Reset: keyword registers load int, main, void, float; pending text and the
// halt flag clear. An error token halts the block: later characters are taken
// and dropped until reset. A pending token is not flushed at end of input.
module keyword_lexer_stream #(
	parameter int MAX_TOKEN_CHARS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [3:0]  token_kind,
	output logic [1:0]  keyword_index,
	output logic [63:0] token_text,
	output logic [7:0]  token_length,
	output logic        text_truncated,
	output logic [1:0]  error_code,
	output logic        last_of_run,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import kls_pkg::*;

	kw_arr_t kw_q;
	pair_t   pair;
	tok_t    head;
	logic    room, push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q[0] <= KW0_RESET;
			kw_q[1] <= KW1_RESET;
			kw_q[2] <= KW2_RESET;
			kw_q[3] <= KW3_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEYWORD_0: kw_q[0] <= cfg_data;
				REG_KEYWORD_1: kw_q[1] <= cfg_data;
				REG_KEYWORD_2: kw_q[2] <= cfg_data;
				REG_KEYWORD_3: kw_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	kls_core #(
		.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_in  (char_in),
		.kw       (kw_q),
		.room     (room),
		.push     (push),
		.pair     (pair)
	);

	kls_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pair        (pair),
		.room        (room),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.head        (head)
	);

	assign token_kind     = head.kind;
	assign keyword_index  = head.kidx;
	assign token_text     = head.text;
	assign token_length   = head.len;
	assign text_truncated = head.trunc;
	assign error_code     = head.err;
	assign last_of_run    = head.last;

endmodule

// ===== rtl/kls_checker.sv =====
`include "keyword_lexer_stream_defines.svh"

module kls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        token_valid,
	input logic        token_ready,
	input logic [3:0]  token_kind,
	input logic [1:0]  keyword_index,
	input logic [63:0] token_text,
	input logic [7:0]  token_length,
	input logic        text_truncated,
	input logic [1:0]  error_code,
	input logic        last_of_run
);
	import kls_pkg::*;

	`KLS_ASSERT_NEXT(a_hold_stalled, token_valid && !token_ready, token_valid && $stable(token_text) && $stable(token_kind) && $stable(last_of_run))

	`KLS_ASSERT_NOW(a_error_clean, token_valid && error_code != ERR_NONE, token_kind == KIND_KEYWORD && keyword_index == 2'd0 && token_text == 64'd0 && token_length == 8'd0 && !text_truncated && last_of_run)

	`KLS_ASSERT_NOW(a_keyword_whole, token_valid && error_code == ERR_NONE && token_kind == KIND_KEYWORD, !text_truncated && token_length != 8'd0)

	`KLS_ASSERT_NEXT(a_halt_after_error, token_valid && token_ready && error_code != ERR_NONE, !token_valid)

endmodule

bind keyword_lexer_stream kls_checker u_kls_checker (.*);
